### design/pearson_correlation_engine_assert.svh
// Assertion macros for the Pearson correlation engine.
// Included by the RTL files that carry concurrent checks; needs clk and rst_n in scope.
`ifndef PEARSON_CORRELATION_ENGINE_ASSERT_SVH
`define PEARSON_CORRELATION_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
`define PCE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PCE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define PCE_ASSERT(lbl, prop, msg)
`define PCE_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### design/pce_pkg.sv
// Shared types and constants for the Pearson correlation engine.
// No dependencies; used by every module of the block.
`default_nettype none
package pce_pkg;
  localparam int MAX_SAMPLES = 65536;
  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W = 34;
  localparam int SQ_W  = 48;
  localparam int ONE_Q14 = 16384;

  typedef struct packed {
    logic signed [15:0] x_value;
    logic signed [15:0] y_value;
    logic               last_cell;
  } in_t;

  typedef struct packed {
    logic signed [15:0] correlation;
    logic               defined;
  } out_t;

  // Sums of one finished vector pair, handed from front to back.
  typedef struct packed {
    logic        [CNT_W-1:0] n;
    logic signed [SUM_W-1:0] sx;
    logic signed [SUM_W-1:0] sy;
    logic signed [SQ_W-1:0]  sxx;
    logic signed [SQ_W-1:0]  syy;
    logic signed [SQ_W-1:0]  sxy;
  } snap_t;
endpackage
`default_nettype wire

### design/pce_front.sv
// Front part: accumulates sample sums and hands them on at each last mark.
// Depends on pce_pkg.
`default_nettype none
module pce_front import pce_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire in_t   in_data,
  output logic       q_valid,
  input  wire logic  q_ready,
  output snap_t      q_data
);
  logic        [CNT_W-1:0] n_r, n_nxt;
  logic signed [SUM_W-1:0] sx_r, sy_r, sx_nxt, sy_nxt;
  logic signed [SQ_W-1:0]  sxx_r, syy_r, sxy_r, sxx_nxt, syy_nxt, sxy_nxt;
  logic signed [31:0]      xx, yy, xy;
  logic                    take, accept;

  assign xx = in_data.x_value * in_data.x_value;
  assign yy = in_data.y_value * in_data.y_value;
  assign xy = in_data.x_value * in_data.y_value;
  // Samples past the limit are dropped until the next last mark.
  assign take = n_r < CNT_W'(MAX_SAMPLES);

  always_comb begin
    n_nxt   = n_r;
    sx_nxt  = sx_r;
    sy_nxt  = sy_r;
    sxx_nxt = sxx_r;
    syy_nxt = syy_r;
    sxy_nxt = sxy_r;
    if (take) begin
      n_nxt   = n_r + 1'b1;
      sx_nxt  = sx_r + SUM_W'(in_data.x_value);
      sy_nxt  = sy_r + SUM_W'(in_data.y_value);
      sxx_nxt = sxx_r + SQ_W'(xx);
      syy_nxt = syy_r + SQ_W'(yy);
      sxy_nxt = sxy_r + SQ_W'(xy);
    end
  end

  assign in_ready = q_ready;
  assign accept   = in_valid && in_ready;
  assign q_valid  = in_valid && in_data.last_cell;
  assign q_data   = '{n: n_nxt, sx: sx_nxt, sy: sy_nxt, sxx: sxx_nxt, syy: syy_nxt,
                      sxy: sxy_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_data.last_cell)) begin
      n_r   <= '0;
      sx_r  <= '0;
      sy_r  <= '0;
      sxx_r <= '0;
      syy_r <= '0;
      sxy_r <= '0;
    end else if (accept) begin
      n_r   <= n_nxt;
      sx_r  <= sx_nxt;
      sy_r  <= sy_nxt;
      sxx_r <= sxx_nxt;
      syy_r <= syy_nxt;
      sxy_r <= sxy_nxt;
    end
  end
endmodule
`default_nettype wire

### design/pce_queue.sv
// Two-entry queue of finished sums between front and back.
// Depends on pce_pkg.
`default_nettype none
module pce_queue import pce_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  wr_valid,
  output logic       wr_ready,
  input  wire snap_t wr_data,
  output logic       rd_valid,
  input  wire logic  rd_ready,
  output snap_t      rd_data
);
  snap_t      mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data  = mem_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

### design/pce_back.sv
// Back part: forms the covariance terms, root and quotient with a shared
// shift-add multiplier, a digit-by-digit root and a restoring divider. Depends on pce_pkg.
`default_nettype none
`include "pearson_correlation_engine_assert.svh"
module pce_back import pce_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  q_valid,
  output logic       q_ready,
  input  wire snap_t q_data,
  output logic       out_valid,
  input  wire logic  out_ready,
  output out_t       out_data
);
  localparam int MUL_STEPS  = 64;
  localparam int SQRT_STEPS = 62;
  localparam int DIV_STEPS  = 77;
  localparam int TW = 68;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_LOAD = 9'b000000010,
    S_MUL  = 9'b000000100,
    S_ACC  = 9'b000001000,
    S_CHK  = 9'b000010000,
    S_NORM = 9'b000100000,
    S_SQRT = 9'b001000000,
    S_DIV  = 9'b010000000,
    S_FIN  = 9'b100000000
  } state_t;

  state_t          state_r;
  snap_t           snap_r;
  logic [2:0]      idx_r;
  logic [6:0]      cnt_r;
  logic [127:0]    ma_r, prod_r;
  logic [63:0]     mb_r, opa, opb;
  logic            psign_r, osign;
  logic [TW-1:0]   a_r, b_r, c_r, sprod;
  logic            cneg_r, def_r, ovf_r;
  logic [123:0]    p_r;
  logic [61:0]     root_r;
  logic [65:0]     srem_r, srem_sh, trial;
  logic [76:0]     num_r;
  logic [63:0]     drem_r, drem_sh;
  logic [15:0]     q_r, mag;
  logic            out_valid_r;
  out_t            out_r;
  logic            fin_load;

  function automatic logic [63:0] mag64(input logic [SQ_W-1:0] v);
    logic [SQ_W-1:0] m;
    m = v[SQ_W-1] ? (~v + 1'b1) : v;
    return 64'(m);
  endfunction

  // Operand selection for the shared multiplier.
  always_comb begin
    opa   = '0;
    opb   = '0;
    osign = 1'b0;
    case (idx_r)
      3'd0: begin opa = 64'(snap_r.n); opb = mag64(snap_r.sxx); end
      3'd1: begin opa = mag64(SQ_W'(snap_r.sx)); opb = opa; end
      3'd2: begin opa = 64'(snap_r.n); opb = mag64(snap_r.syy); end
      3'd3: begin opa = mag64(SQ_W'(snap_r.sy)); opb = opa; end
      3'd4: begin
        opa = 64'(snap_r.n); opb = mag64(snap_r.sxy); osign = snap_r.sxy[SQ_W-1];
      end
      3'd5: begin
        opa = mag64(SQ_W'(snap_r.sx)); opb = mag64(SQ_W'(snap_r.sy));
        osign = snap_r.sx[SUM_W-1] ^ snap_r.sy[SUM_W-1];
      end
      default: begin opa = 64'(a_r[61:0]); opb = 64'(b_r[61:0]); end
    endcase
  end

  assign sprod   = psign_r ? (~{4'b0, prod_r[63:0]} + 1'b1) : {4'b0, prod_r[63:0]};
  assign srem_sh = {srem_r[63:0], p_r[123:122]};
  assign trial   = {2'b0, root_r, 2'b01};
  assign drem_sh = {drem_r[62:0], num_r[76]};
  assign mag     = !def_r ? 16'd0 :
                   (ovf_r || q_r > 16'(ONE_Q14)) ? 16'(ONE_Q14) : q_r;
  assign fin_load = (state_r == S_FIN) && (!out_valid_r || out_ready);
  assign q_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (fin_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            snap_r  <= q_data;
            idx_r   <= 3'd0;
            state_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          ma_r    <= {64'b0, opa};
          mb_r    <= opb;
          psign_r <= osign;
          prod_r  <= '0;
          cnt_r   <= '0;
          state_r <= S_MUL;
        end
        S_MUL: begin
          if (mb_r[0]) prod_r <= prod_r + ma_r;
          ma_r  <= ma_r << 1;
          mb_r  <= mb_r >> 1;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 7'(MUL_STEPS - 1)) state_r <= S_ACC;
        end
        S_ACC: begin
          idx_r <= idx_r + 1'b1;
          case (idx_r)
            3'd0: begin a_r <= sprod; state_r <= S_LOAD; end
            3'd1: begin a_r <= a_r - sprod; state_r <= S_LOAD; end
            3'd2: begin b_r <= sprod; state_r <= S_LOAD; end
            3'd3: begin b_r <= b_r - sprod; state_r <= S_LOAD; end
            3'd4: begin c_r <= sprod; state_r <= S_LOAD; end
            3'd5: begin c_r <= c_r - sprod; state_r <= S_CHK; end
            default: begin
              p_r     <= prod_r[123:0];
              root_r  <= '0;
              srem_r  <= '0;
              cnt_r   <= '0;
              state_r <= S_SQRT;
            end
          endcase
        end
        S_CHK: begin
          if (a_r[TW-1] || a_r == '0 || b_r[TW-1] || b_r == '0) begin
            def_r   <= 1'b0;
            state_r <= S_FIN;
          end else begin
            def_r   <= 1'b1;
            cneg_r  <= c_r[TW-1];
            c_r     <= c_r[TW-1] ? (~c_r + 1'b1) : c_r;
            state_r <= S_NORM;
          end
        end
        S_NORM: begin
          // Divide each sum of squares by four until it fits 62 bits; the
          // covariance follows by the square root of the same factor.
          if (a_r[TW-1:62] != '0) begin
            a_r <= a_r >> 2;
            c_r <= c_r >> 1;
          end else if (b_r[TW-1:62] != '0) begin
            b_r <= b_r >> 2;
            c_r <= c_r >> 1;
          end else begin
            if (c_r[TW-1:62] != '0) c_r <= TW'(1) << 62;
            idx_r   <= 3'd6;
            state_r <= S_LOAD;
          end
        end
        S_SQRT: begin
          p_r <= p_r << 2;
          if (srem_sh >= trial) begin
            srem_r <= srem_sh - trial;
            root_r <= {root_r[60:0], 1'b1};
          end else begin
            srem_r <= srem_sh;
            root_r <= {root_r[60:0], 1'b0};
          end
          if (cnt_r == 7'(SQRT_STEPS - 1)) begin
            cnt_r   <= '0;
            state_r <= S_DIV;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_DIV: begin
          if (cnt_r == '0 && drem_r == '0 && q_r == '0 && !ovf_r && num_r == '0) begin
            // First visit: set up the numerator from the finished root.
            if (root_r == '0) begin
              def_r   <= 1'b0;
              state_r <= S_FIN;
            end else begin
              num_r <= {c_r[62:0], 14'b0} + 77'(root_r >> 1);
              cnt_r <= 7'd1;
            end
          end else begin
            num_r <= num_r << 1;
            if (drem_sh >= {2'b0, root_r}) begin
              drem_r <= drem_sh - {2'b0, root_r};
              q_r    <= {q_r[14:0], 1'b1};
            end else begin
              drem_r <= drem_sh;
              q_r    <= {q_r[14:0], 1'b0};
            end
            ovf_r <= ovf_r | q_r[15];
            cnt_r <= cnt_r + 1'b1;
            if (cnt_r == 7'(DIV_STEPS)) state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (fin_load) begin
            out_r.correlation <= cneg_r ? (~mag + 1'b1) : mag;
            out_r.defined     <= def_r;
            state_r           <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      // Divider registers start clean for every vector pair.
      if (state_r == S_IDLE) begin
        drem_r <= '0;
        q_r    <= '0;
        ovf_r  <= 1'b0;
        num_r  <= '0;
        cneg_r <= 1'b0;
      end
    end
  end

  `PCE_ASSERT(a_fin_before_valid, $rose(out_valid_r) |-> $past(state_r == S_FIN), "result without finish")
  `PCE_ASSERT(a_undef_zero, (out_valid_r && !out_r.defined) |-> (out_r.correlation == 16'd0), "undefined result not zero")
  `PCE_ASSERT(a_mag_range, (out_valid_r && out_r.defined) |-> ($signed(out_r.correlation) <= 16'sd16384 && $signed(out_r.correlation) >= -16'sd16384), "correlation out of range")
endmodule
`default_nettype wire

### design/pearson_correlation_engine.sv
// Top level of the Pearson correlation engine.
// Depends on pce_pkg, pce_front, pce_queue and pce_back.
//
// Usage: each input request carries one (x, y) sample pair in Q4.12 and a
// last_cell mark. Requests are taken on in_valid && in_ready. Requests without
// the mark produce nothing; the marked one closes the vector pair and yields
// one result request (correlation in Q1.14, defined flag) on out_valid/out_ready.
// Throughput: the front accepts one sample per cycle while the two-entry queue
// of finished sums has room. The back works one vector pair at a time on a
// shared 1-bit-per-cycle multiplier (seven products), a scaling step (repeated
// once per pair of bits a sum of squares holds past 62), a square root and a
// divider; pairs closing faster than the back finishes them fill the queue and
// then hold in_ready low.
// Reset (rst_n low, synchronous) clears the sums, the queue and the back
// sequencer. A stalled receiver holds the result in the output register;
// the back then waits and the front keeps accepting until the queue is full.
`default_nettype none
module pearson_correlation_engine import pce_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);
  logic  fq_valid, fq_ready, bq_valid, bq_ready;
  snap_t fq_data, bq_data;

  pce_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data)
  );

  pce_queue u_queue (
    .clk, .rst_n,
    .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_data),
    .rd_valid(bq_valid), .rd_ready(bq_ready), .rd_data(bq_data)
  );

  pce_back u_back (
    .clk, .rst_n,
    .q_valid(bq_valid), .q_ready(bq_ready), .q_data(bq_data),
    .out_valid, .out_ready, .out_data
  );
endmodule
`default_nettype wire
